FILE: src/tmpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpm_pkg - shared types and constants of the trie pattern matcher
// Sizes of the edge table and the walk set, status codes, sequencer states
// and the control bundle between the sequencer and the walk set.
// ----------------------------------------------------------------------------
package tmpm_pkg;

    localparam int NODE_SLOTS = 255;
    localparam int MAX_DEPTH  = 32;

    localparam int NODE_W  = $clog2(NODE_SLOTS + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int WALK_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // edge entry: parent node above the 8-bit character
    localparam int EDGE_W  = NODE_W + 8;

    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FIN
    } t_state;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SCAN   = 1'b1;

    typedef struct packed {
        logic start;   // empty the next-walk set
        logic append;  // add a surviving walk
        logic commit;  // next set becomes the live set
        logic clear;   // drop all live walks
    } t_walk_ctrl;

endpackage
`default_nettype wire

FILE: src/trie_multi_pattern_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trie_multi_pattern_matcher - trie based multi-pattern substring matcher
// Insert beats build a trie in an edge table, scan beats walk it.
// ----------------------------------------------------------------------------
// Each input beat triggers one sweep of the edge RAM, one entry per cycle;
// all live walks are compared against each edge in the same cycle. An insert
// beat of a pattern that hit an error or its depth limit skips the sweep. The
// final beat of a pattern or a text gives one result beat: tdata bit 0 is the
// scan match flag, bits 2:1 the insert status. The result register lets the
// next beat enter while a result waits; only a final beat holds in its last
// cycle until the previous result has been taken.
module trie_multi_pattern_matcher (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] byte_value
    input  wire logic       i_s_tuser,   // [0] command
    input  wire logic       i_s_tlast,   // last_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata    // [0] matched, [2:1] status, [7:3] zero
);

    tmpm_pkg::t_state r_state, n_state;
    logic r_cmd, r_last;
    logic [7:0] r_ch;
    tmpm_pkg::t_node r_count, r_ins_node, r_addr, r_pa, r_found_node;
    logic [tmpm_pkg::DEPTH_W-1:0] r_ins_depth;
    tmpm_pkg::t_status r_ins_err;
    logic r_pv, r_found, r_match;
    logic r_out_valid, r_out_matched;
    tmpm_pkg::t_status r_out_status;

    logic [tmpm_pkg::EDGE_W-1:0] w_edge;
    logic w_end, w_hit, w_accept, w_sweep_done, w_beat_ok;
    logic w_ewe, w_endwe, w_endwd;
    tmpm_pkg::t_node w_endaddr;
    tmpm_pkg::t_walk_ctrl w_wctrl;
    logic [7:0] w_low;

    assign o_s_tready = (r_state == tmpm_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_low = (i_s_tdata >= 8'h41 && i_s_tdata <= 8'h5A) ? i_s_tdata + 8'd32 : i_s_tdata;
    assign w_sweep_done = (r_addr == r_count) && !r_pv;
    assign w_beat_ok = r_pv && (w_edge[7:0] == r_ch);

    tmpm_ram #(.WIDTH(tmpm_pkg::EDGE_W), .DEPTH(tmpm_pkg::NODE_SLOTS),
               .AW(tmpm_pkg::NODE_W)) u_edge (
        .i_clk  (i_clk),
        .i_we   (w_ewe),
        .i_waddr(r_count),
        .i_wdata({r_ins_node, r_ch}),
        .i_raddr(r_addr),
        .o_rdata(w_edge)
    );

    tmpm_ram #(.WIDTH(1), .DEPTH(tmpm_pkg::NODE_SLOTS), .AW(tmpm_pkg::NODE_W)) u_end (
        .i_clk  (i_clk),
        .i_we   (w_endwe),
        .i_waddr(w_endaddr),
        .i_wdata(w_endwd),
        .i_raddr(r_addr),
        .o_rdata(w_end)
    );

    tmpm_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_wctrl),
        .i_parent(w_edge[tmpm_pkg::EDGE_W-1:8]),
        .i_child (r_pa + 1'b1),
        .o_hit   (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_wctrl   = '0;
        w_ewe     = 1'b0;
        w_endwe   = 1'b0;
        w_endwd   = 1'b0;
        w_endaddr = r_count;
        unique case (r_state)
            tmpm_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == tmpm_pkg::CMD_SCAN) begin
                        w_wctrl.start = 1'b1;
                        n_state = tmpm_pkg::S_SWEEP;
                    end else if (r_ins_err != tmpm_pkg::ST_OK ||
                                 r_ins_depth >= tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH)) begin
                        n_state = tmpm_pkg::S_FIN;
                    end else begin
                        n_state = tmpm_pkg::S_SWEEP;
                    end
                end
            end
            tmpm_pkg::S_SWEEP: begin
                if (r_cmd == tmpm_pkg::CMD_SCAN) begin
                    w_wctrl.append = w_beat_ok && w_hit;
                end
                if (w_sweep_done) begin
                    if (r_cmd == tmpm_pkg::CMD_SCAN) begin
                        w_wctrl.commit = 1'b1;
                    end else if (!r_found &&
                                 r_count != tmpm_pkg::NODE_W'(tmpm_pkg::NODE_SLOTS)) begin
                        w_ewe   = 1'b1;
                        w_endwe = 1'b1;
                    end
                    n_state = tmpm_pkg::S_FIN;
                end
            end
            tmpm_pkg::S_FIN: begin
                if (!r_last) begin
                    n_state = tmpm_pkg::S_IDLE;
                end else if (!r_out_valid || i_m_tready) begin
                    if (r_cmd == tmpm_pkg::CMD_INSERT) begin
                        w_endwe   = (r_ins_err == tmpm_pkg::ST_OK);
                        w_endwd   = 1'b1;
                        w_endaddr = r_ins_node - 1'b1;
                    end else begin
                        w_wctrl.clear = 1'b1;
                    end
                    n_state = tmpm_pkg::S_IDLE;
                end
            end
            default: n_state = tmpm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ins_node  <= '0;
            r_ins_depth <= '0;
            r_ins_err   <= tmpm_pkg::ST_OK;
            r_match     <= 1'b0;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                tmpm_pkg::S_IDLE: begin
                    r_addr  <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    if (w_accept && i_s_tuser == tmpm_pkg::CMD_INSERT &&
                        r_ins_err == tmpm_pkg::ST_OK &&
                        r_ins_depth >= tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH)) begin
                        r_ins_err <= tmpm_pkg::ST_LONG;
                    end
                end
                tmpm_pkg::S_SWEEP: begin
                    // advance the read pointer, the registered read data follows in the next cycle
                    r_pv <= (r_addr != r_count);
                    if (r_addr != r_count) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_cmd == tmpm_pkg::CMD_INSERT && w_beat_ok &&
                        w_edge[tmpm_pkg::EDGE_W-1:8] == r_ins_node) begin
                        r_found <= 1'b1;
                    end
                    if (r_cmd == tmpm_pkg::CMD_SCAN && w_beat_ok && w_hit && w_end) begin
                        r_match <= 1'b1;
                    end
                    if (w_sweep_done && r_cmd == tmpm_pkg::CMD_INSERT) begin
                        if (r_found) begin
                            r_ins_node  <= r_found_node;
                            r_ins_depth <= r_ins_depth + 1'b1;
                        end else if (r_count == tmpm_pkg::NODE_W'(tmpm_pkg::NODE_SLOTS)) begin
                            r_ins_err <= tmpm_pkg::ST_FULL;
                        end else begin
                            r_ins_node  <= r_count + 1'b1;
                            r_ins_depth <= r_ins_depth + 1'b1;
                            r_count     <= r_count + 1'b1;
                        end
                    end
                end
                tmpm_pkg::S_FIN: begin
                    if (r_last && (!r_out_valid || i_m_tready)) begin
                        r_out_valid <= 1'b1;
                        if (r_cmd == tmpm_pkg::CMD_INSERT) begin
                            r_ins_node  <= '0;
                            r_ins_depth <= '0;
                            r_ins_err   <= tmpm_pkg::ST_OK;
                        end else begin
                            r_match <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_s_tuser;
            r_ch   <= w_low;
            r_last <= i_s_tlast;
        end
        if (r_state == tmpm_pkg::S_SWEEP) begin
            r_pa <= r_addr;
            if (w_beat_ok && w_edge[tmpm_pkg::EDGE_W-1:8] == r_ins_node) begin
                r_found_node <= r_pa + 1'b1;
            end
        end
        if (r_state == tmpm_pkg::S_FIN && r_last && (!r_out_valid || i_m_tready)) begin
            r_out_matched <= (r_cmd == tmpm_pkg::CMD_SCAN) ? r_match : 1'b0;
            r_out_status  <= (r_cmd == tmpm_pkg::CMD_INSERT) ? r_ins_err : tmpm_pkg::ST_OK;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_status, r_out_matched};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tmpm_pkg::NODE_W'(tmpm_pkg::NODE_SLOTS))
        else $error("node count beyond table size");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tmpm_pkg::S_SWEEP |-> r_addr <= r_count)
        else $error("sweep pointer past node count");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ins_depth <= tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH))
        else $error("insert depth beyond limit");

    a_node_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ins_depth != '0) |-> (r_ins_node != '0))
        else $error("insert cursor at root with nonzero depth");

endmodule
`default_nettype wire

FILE: src/tmpm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpm_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tmpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/tmpm_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpm_walk - live walk set of the text scan
// Holds the cursors of all live walks and compares an edge's parent against
// all of them at once; survivors collect in a next set that is committed at
// the end of each scan sweep.
// ----------------------------------------------------------------------------
module tmpm_walk (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tmpm_pkg::t_walk_ctrl i_ctrl,
    input  wire tmpm_pkg::t_node     i_parent,
    input  wire tmpm_pkg::t_node     i_child,
    output logic                     o_hit
);

    tmpm_pkg::t_node r_cur  [tmpm_pkg::MAX_DEPTH];
    tmpm_pkg::t_node r_ncur [tmpm_pkg::MAX_DEPTH];
    logic [tmpm_pkg::MAX_DEPTH-1:0] r_val;
    logic [tmpm_pkg::MAX_DEPTH-1:0] r_nval;
    logic [tmpm_pkg::DEPTH_W-1:0]   r_ncnt;

    // the root walk starts fresh on every byte
    always_comb begin
        o_hit = (i_parent == '0);
        for (int i = 0; i < tmpm_pkg::MAX_DEPTH; i++) begin
            if (r_val[i] && r_cur[i] == i_parent) begin
                o_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_nval <= '0;
            r_ncnt <= '0;
        end else begin
            if (i_ctrl.start) begin
                r_nval <= '0;
                r_ncnt <= '0;
            end else if (i_ctrl.append &&
                         r_ncnt < tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH)) begin
                r_nval[r_ncnt[tmpm_pkg::WALK_W-1:0]] <= 1'b1;
                r_ncnt <= r_ncnt + 1'b1;
            end
            if (i_ctrl.clear) begin
                r_val <= '0;
            end else if (i_ctrl.commit) begin
                r_val <= r_nval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && r_ncnt < tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH)) begin
            r_ncur[r_ncnt[tmpm_pkg::WALK_W-1:0]] <= i_child;
        end
        if (i_ctrl.commit) begin
            r_cur <= r_ncur;
        end
    end

    a_ncnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= tmpm_pkg::DEPTH_W'(tmpm_pkg::MAX_DEPTH))
        else $error("next walk count overflow");

    a_start_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> r_ncnt == '0 && r_nval == '0)
        else $error("next walk set not emptied");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_val == '0)
        else $error("walks not dropped");

endmodule
`default_nettype wire

FILE: tb/sv/tb_trie_multi_pattern_matcher.sv
// ----------------------------------------------------------------------------
// tb_trie_multi_pattern_matcher - self-checking bench of the trie matcher
// Builds tries from insert beats and scans text beats against them. A short
// directed table covers byte extremes, case lowering and interleaving, then
// a too-long insert. Random patterns and texts follow under several idle and
// stall mixes. Every result beat is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_trie_multi_pattern_matcher;
    import tmpm_pkg::*;

    localparam int RANDOM_BEATS = 1450;
    localparam int DRAIN_CYCLES = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] byte_value
    logic       i_s_tuser;   // [0] command
    logic       i_s_tlast;   // last_byte
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [0] matched, [2:1] status, [7:3] zero

    trie_multi_pattern_matcher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    typedef struct {
        logic    matched;
        t_status status;
    } t_verdict;

    typedef struct {
        logic       cmd;
        logic [7:0] chr;
        logic       last;
        bit         typed;
        t_verdict   want;
    } t_row;

    // trie mirror
    logic [7:0] trie_parent[NODE_SLOTS];
    logic [7:0] trie_char[NODE_SLOTS];
    bit         trie_end[NODE_SLOTS+1];
    int         trie_nodes;
    int         pat_node;
    int         pat_depth;
    t_status    pat_err;
    int         live_walks[$];
    bit         text_hit;

    t_verdict   pending_verdicts[$];
    int         mismatches;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         beats_sent;

    function automatic logic [7:0] fold_case(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic int trie_child(int parent, logic [7:0] c);
        for (int e = 0; e < trie_nodes; e++)
            if (trie_parent[e] == parent && trie_char[e] == c) return e + 1;
        return 0;
    endfunction

    // Advance the mirror by one beat; returns 1 when the beat ends a run.
    function automatic bit trie_beat(logic cmd, logic [7:0] raw, logic last,
                                     output t_verdict v);
        logic [7:0] c;
        int         child;
        int         next_walks[$];
        c = fold_case(raw);
        v.matched = 1'b0;
        v.status  = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (pat_err == ST_OK) begin
                if (pat_depth >= MAX_DEPTH) begin
                    pat_err = ST_LONG;
                end else begin
                    child = trie_child(pat_node, c);
                    if (child == 0 && trie_nodes >= NODE_SLOTS) begin
                        pat_err = ST_FULL;
                    end else begin
                        if (child == 0) begin
                            trie_parent[trie_nodes] = pat_node[7:0];
                            trie_char[trie_nodes]   = c;
                            trie_nodes++;
                            child = trie_nodes;
                            trie_end[child] = 1'b0;
                        end
                        pat_node = child;
                        pat_depth++;
                    end
                end
            end
            if (!last) return 0;
            if (pat_err == ST_OK) trie_end[pat_node] = 1'b1;
            v.status  = pat_err;
            pat_node  = 0;
            pat_depth = 0;
            pat_err   = ST_OK;
            return 1;
        end
        live_walks.push_back(0);  // fresh walk from the root
        foreach (live_walks[i]) begin
            child = trie_child(live_walks[i], c);
            if (child != 0) begin
                if (trie_end[child]) text_hit = 1'b1;
                if (next_walks.size() < MAX_DEPTH) next_walks.push_back(child);
            end
        end
        live_walks = next_walks;
        if (!last) return 0;
        v.matched = text_hit;
        text_hit  = 1'b0;
        live_walks.delete();
        return 1;
    endfunction

    task automatic send_beat(logic cmd, logic [7:0] chr, logic last,
                             bit typed = 0, t_verdict want = '{1'b0, ST_OK});
        t_verdict v;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= chr;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (trie_beat(cmd, chr, last, v)) pending_verdicts.push_back(typed ? want : v);
        beats_sent++;
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] b;
        b = 8'h61 + 8'($urandom_range(5));
        return $urandom_range(1) ? b - 8'd32 : b;
    endfunction

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
        endcase
    endtask

    // result side
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: tdata=%h", o_m_tdata);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_m_tdata[0] !== want.matched || o_m_tdata[2:1] !== want.status
                            || o_m_tdata[7:3] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: want matched=%0d status=%0d, got tdata=%h",
                                     want.matched, want.status, o_m_tdata);
                    end
                end
            end
        end
    end

    t_row directed[] = '{
        '{CMD_SCAN,   8'h78, 1'b1, 1, '{1'b0, ST_OK}},   // empty trie
        '{CMD_INSERT, 8'h41, 1'b1, 1, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h61, 1'b1, 1, '{1'b1, ST_OK}},
        '{CMD_INSERT, 8'h00, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_INSERT, 8'hFF, 1'b1, 1, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h00, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'hFF, 1'b1, 1, '{1'b1, ST_OK}},
        '{CMD_INSERT, 8'h5A, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_INSERT, 8'h40, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_INSERT, 8'h5B, 1'b1, 1, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h7A, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h40, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h7B, 1'b1, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h5A, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_INSERT, 8'h42, 1'b1, 0, '{1'b0, ST_OK}},   // interleaved pattern
        '{CMD_SCAN,   8'h62, 1'b1, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h80, 1'b0, 0, '{1'b0, ST_OK}},
        '{CMD_SCAN,   8'h5B, 1'b1, 0, '{1'b0, ST_OK}}
    };

    initial begin
        int len;
        int kind;
        bit drained;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tuser  = CMD_INSERT;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        trie_nodes = 0;
        pat_node   = 0;
        pat_depth  = 0;
        pat_err    = ST_OK;
        text_hit   = 1'b0;
        drained    = 1'b0;
        foreach (trie_end[i]) trie_end[i] = 1'b0;
        set_idling(0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].cmd, directed[i].chr, directed[i].last,
                      directed[i].typed, directed[i].want);
        // too long: one byte past the depth limit
        for (int i = 0; i <= MAX_DEPTH; i++)
            send_beat(CMD_INSERT, 8'h71, i == MAX_DEPTH, i == MAX_DEPTH, '{1'b0, ST_LONG});

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            set_idling(beats_sent / 120);
            if (!drained && beats_sent >= 700) begin
                // hold off until the block has drained
                drained = 1'b1;
                i_s_tvalid <= 1'b0;
                while (pending_verdicts.size() != 0) @(posedge i_clk);
            end
            kind = $urandom_range(99);
            if (kind < 35) begin
                len = ($urandom_range(24) == 0) ? $urandom_range(MAX_DEPTH + 1, MAX_DEPTH + 4)
                                                : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_beat(CMD_INSERT, pick_letter(), i == len - 1);
            end else if (kind < 90) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_beat(CMD_SCAN, $urandom_range(9) ? pick_letter()
                                                         : 8'($urandom_range(255)),
                              i == len - 1);
            end else begin
                send_beat($urandom_range(1), 8'($urandom_range(255)), $urandom_range(1));
            end
        end
        i_s_tvalid <= 1'b0;
        // close any open pattern or text so that nothing is left half built
        send_beat(CMD_INSERT, 8'h61, 1'b1);
        send_beat(CMD_SCAN, 8'h61, 1'b1);
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_trie_multi_pattern_matcher: PASS");
        end else begin
            $display("tb_trie_multi_pattern_matcher: FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_trie_multi_pattern_matcher: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/tmpm_pkg.sv
src/tmpm_ram.sv
src/tmpm_walk.sv
src/trie_multi_pattern_matcher.sv
tb/sv/tb_trie_multi_pattern_matcher.sv
